// ===== rtl/hfwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfwm_pkg : shared types and helpers for the humidity frame watering monitor
// item kinds, register indexes, field widths, moisture arithmetic
// ----------------------------------------------------------------------------
package hfwm_pkg;

    localparam int unsigned FRAME_BITS  = 40;
    localparam int unsigned COUNT_W     = 6;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned TLIM_W      = 6;
    localparam int unsigned HLIM_W      = 7;
    localparam int unsigned PCT_W       = 7;
    localparam int unsigned CFG_IDX_W   = 2;

    localparam logic [TLIM_W-1:0] TLIM_RESET = 6'd35;
    localparam logic [HLIM_W-1:0] HLIM_RESET = 7'd50;
    localparam logic [BYTE_W-1:0] THR_RESET  = 8'd80;

    // item kinds on the sample channel; the fourth code is ignored
    typedef enum logic [1:0] {
        KIND_START   = 2'd0,
        KIND_BIT     = 2'd1,
        KIND_READING = 2'd2
    } kind_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_LIMIT = 2'd0,
        REG_HUM_LIMIT  = 2'd1,
        REG_MOIST_THR  = 2'd2
    } cfg_idx_t;

    // floor(100*(255-g)/255), reciprocal form exact below 2^16
    function automatic logic [PCT_W-1:0] moisture_pct(input logic [BYTE_W-1:0] g);
        logic [BYTE_W-1:0] x;
        logic [14:0]       y;
        logic [15:0]       q;
        x = 8'd255 - g;
        y = 15'(x) * 15'd100;
        q = (16'(y) + 16'(y >> 8) + 16'd1) >> 8;
        return q[PCT_W-1:0];
    endfunction

    // pump runs while moisture is below the threshold; above 100 it always runs
    function automatic logic pump_demand(input logic [BYTE_W-1:0] g,
                                         input logic [BYTE_W-1:0] thr);
        logic [14:0] lhs;
        logic [14:0] rhs;
        logic [BYTE_W-1:0] gap;
        gap = 8'd100 - thr;
        lhs = 15'(g) * 15'd100;
        rhs = 15'(gap) * 15'd255;
        if (thr > 8'd100)
        begin
            return 1'b1;
        end
        return (lhs > rhs);
    endfunction

endpackage

// ===== rtl/hfwm_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfwm channel interfaces
// sample, result and configuration write channels with valid/ready
// ----------------------------------------------------------------------------
interface hfwm_sample_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  kind;
    logic                        bit_value;
    logic [hfwm_pkg::BYTE_W-1:0] reading_msb_first;
    logic [hfwm_pkg::BYTE_W-1:0] reading_lsb_first;

    modport source (output valid, kind, bit_value, reading_msb_first,
                    reading_lsb_first, input ready);
    modport sink   (input valid, kind, bit_value, reading_msb_first,
                    reading_lsb_first, output ready);
endinterface

interface hfwm_result_if;
    logic                        valid;
    logic                        ready;
    logic [hfwm_pkg::BYTE_W-1:0] humidity;
    logic [hfwm_pkg::BYTE_W-1:0] temperature;
    logic                        alarm;
    logic                        pump_on;
    logic [hfwm_pkg::PCT_W-1:0]  moisture_percent;
    logic                        frame_done;
    logic                        checksum_ok;

    modport source (output valid, humidity, temperature, alarm, pump_on,
                    moisture_percent, frame_done, checksum_ok, input ready);
    modport sink   (input valid, humidity, temperature, alarm, pump_on,
                    moisture_percent, frame_done, checksum_ok, output ready);
endinterface

interface hfwm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [hfwm_pkg::CFG_IDX_W-1:0] index;
    logic [hfwm_pkg::BYTE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/humidity_frame_watering_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_frame_watering_monitor
// sensor frame receiver with checksum, converter reading filter, temperature
// and humidity alarm, soil moisture percent and pump demand
// ----------------------------------------------------------------------------
//  channel   role    payload
//  sample    sink    kind, bit_value, reading_msb_first, reading_lsb_first
//  result    source  humidity, temperature, alarm, pump_on, moisture_percent,
//                    frame_done, checksum_ok
//  cfg       sink    index, data (always ready)
//
//  a sample transaction updates the state and loads the result register at the
//  same edge, so one item per cycle is sustained while results are taken;
//  the result register frees in the cycle it is taken, so sample stays ready
//  while the result side accepts; it stalls only while a result waits
//  reset clears frame, counters, held values and restores register defaults
// ----------------------------------------------------------------------------
module humidity_frame_watering_monitor (
    input  logic                  clk,
    input  logic                  rst_n,
    hfwm_sample_if.sink           sample,
    hfwm_result_if.source         result,
    hfwm_cfg_if.sink              cfg
);

    // configuration registers
    logic [hfwm_pkg::TLIM_W-1:0] temp_limit_reg;
    logic [hfwm_pkg::HLIM_W-1:0] hum_limit_reg;
    logic [hfwm_pkg::BYTE_W-1:0] moist_thr_reg;

    // block state
    logic [hfwm_pkg::FRAME_BITS-1:0] frame_reg,    frame_next;
    logic [hfwm_pkg::COUNT_W-1:0]    count_reg,    count_next;
    logic [hfwm_pkg::BYTE_W-1:0]     hum_reg,      hum_next;
    logic [hfwm_pkg::BYTE_W-1:0]     temp_reg,     temp_next;
    logic [hfwm_pkg::BYTE_W-1:0]     reading_reg,  reading_next;

    // result register
    logic                            res_valid_reg;
    logic [hfwm_pkg::BYTE_W-1:0]     res_hum_reg;
    logic [hfwm_pkg::BYTE_W-1:0]     res_temp_reg;
    logic                            res_alarm_reg, res_alarm_next;
    logic                            res_pump_reg,  res_pump_next;
    logic [hfwm_pkg::PCT_W-1:0]      res_pct_reg,   res_pct_next;
    logic                            res_done_reg,  res_done_next;
    logic                            res_ok_reg,    res_ok_next;

    logic                            sample_fire;
    logic [hfwm_pkg::FRAME_BITS-1:0] shifted;
    logic [hfwm_pkg::BYTE_W-1:0]     byte_sum;

    assign sample.ready = !res_valid_reg || result.ready;
    assign sample_fire  = sample.valid && sample.ready;
    assign cfg.ready    = 1'b1;

    // frame with the new bit shifted in, and its checksum over four bytes
    assign shifted  = {frame_reg[hfwm_pkg::FRAME_BITS-2:0], sample.bit_value};
    assign byte_sum = shifted[39:32] + shifted[31:24] + shifted[23:16] + shifted[15:8];

    // state update for one item
    always_comb
    begin
        frame_next    = frame_reg;
        count_next    = count_reg;
        hum_next      = hum_reg;
        temp_next     = temp_reg;
        reading_next  = reading_reg;
        res_done_next = 1'b0;
        res_ok_next   = 1'b0;
        case (sample.kind)
            hfwm_pkg::KIND_START:
            begin
                frame_next = '0;
                count_next = '0;
            end
            hfwm_pkg::KIND_BIT:
            begin
                // bits past the end of a frame are dropped
                if (count_reg < hfwm_pkg::COUNT_W'(hfwm_pkg::FRAME_BITS))
                begin
                    frame_next = shifted;
                    count_next = count_reg + 1'b1;
                    if (count_reg == hfwm_pkg::COUNT_W'(hfwm_pkg::FRAME_BITS - 1))
                    begin
                        res_done_next = 1'b1;
                        if (byte_sum == shifted[7:0])
                        begin
                            res_ok_next = 1'b1;
                            hum_next    = shifted[39:32];
                            temp_next   = shifted[23:16];
                        end
                    end
                end
            end
            hfwm_pkg::KIND_READING:
            begin
                // keep the last good value unless both copies agree
                if (sample.reading_msb_first == sample.reading_lsb_first)
                begin
                    reading_next = sample.reading_msb_first;
                end
            end
            default:
            begin
                frame_next = frame_reg;
            end
        endcase
    end

    // result fields from the state after the item
    always_comb
    begin
        res_alarm_next = (temp_next > {2'b00, temp_limit_reg})
                      || (hum_next > {1'b0, hum_limit_reg});
        res_pump_next  = hfwm_pkg::pump_demand(reading_next, moist_thr_reg);
        res_pct_next   = hfwm_pkg::moisture_pct(reading_next);
    end

    // configuration writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_limit_reg <= hfwm_pkg::TLIM_RESET;
            hum_limit_reg  <= hfwm_pkg::HLIM_RESET;
            moist_thr_reg  <= hfwm_pkg::THR_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                hfwm_pkg::REG_TEMP_LIMIT: temp_limit_reg <= cfg.data[hfwm_pkg::TLIM_W-1:0];
                hfwm_pkg::REG_HUM_LIMIT:  hum_limit_reg  <= cfg.data[hfwm_pkg::HLIM_W-1:0];
                hfwm_pkg::REG_MOIST_THR:  moist_thr_reg  <= cfg.data;
                default:                  moist_thr_reg  <= moist_thr_reg;
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg   <= '0;
            count_reg   <= '0;
            hum_reg     <= '0;
            temp_reg    <= '0;
            reading_reg <= '0;
        end
        else if (sample_fire)
        begin
            frame_reg   <= frame_next;
            count_reg   <= count_next;
            hum_reg     <= hum_next;
            temp_reg    <= temp_next;
            reading_reg <= reading_next;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (sample_fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (sample_fire)
        begin
            res_hum_reg   <= hum_next;
            res_temp_reg  <= temp_next;
            res_alarm_reg <= res_alarm_next;
            res_pump_reg  <= res_pump_next;
            res_pct_reg   <= res_pct_next;
            res_done_reg  <= res_done_next;
            res_ok_reg    <= res_ok_next;
        end
    end

    assign result.valid            = res_valid_reg;
    assign result.humidity         = res_hum_reg;
    assign result.temperature      = res_temp_reg;
    assign result.alarm            = res_alarm_reg;
    assign result.pump_on          = res_pump_reg;
    assign result.moisture_percent = res_pct_reg;
    assign result.frame_done       = res_done_reg;
    assign result.checksum_ok      = res_ok_reg;

endmodule

// ===== sim/hfwm_monitor_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfwm_monitor_checker : result predictor and scoreboard
// follows every sample, result and configuration transaction of the humidity
// frame watering monitor, predicts each result from its own copy of the
// frame, reading and register state, and compares it field by field
// ----------------------------------------------------------------------------
module hfwm_monitor_checker (
    input  logic   clk,
    input  logic   rst_n,
    hfwm_sample_if sample,
    hfwm_result_if result,
    hfwm_cfg_if    cfg,
    output int     fail_count,
    output int     pending
);
    import hfwm_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] humidity;
        logic [BYTE_W-1:0] temperature;
        logic              alarm;
        logic              pump_on;
        logic [PCT_W-1:0]  moisture_percent;
        logic              frame_done;
        logic              checksum_ok;
    } monitor_report_t;

    // predicted state of the block
    logic [FRAME_BITS-1:0] frame_bits;
    logic [COUNT_W-1:0]    bits_seen;
    logic [BYTE_W-1:0]     hum_held;
    logic [BYTE_W-1:0]     temp_held;
    logic [BYTE_W-1:0]     reading_held;
    logic [TLIM_W-1:0]     temp_limit;
    logic [HLIM_W-1:0]     hum_limit;
    logic [BYTE_W-1:0]     moist_thr;

    monitor_report_t predicted_reports[$];
    int              mismatches;

    assign fail_count = mismatches;

    // apply one sample transaction and return the report it should produce
    function automatic monitor_report_t advance_monitor(input logic [1:0]        kind,
                                                        input logic              bitv,
                                                        input logic [BYTE_W-1:0] msb,
                                                        input logic [BYTE_W-1:0] lsb);
        monitor_report_t r;
        logic [BYTE_W-1:0] sum8;
        r.frame_done  = 1'b0;
        r.checksum_ok = 1'b0;
        case (kind)
            KIND_START:
            begin
                frame_bits = '0;
                bits_seen  = '0;
            end
            KIND_BIT:
            begin
                // bits past the fortieth are dropped
                if (bits_seen < FRAME_BITS)
                begin
                    frame_bits = {frame_bits[FRAME_BITS-2:0], bitv};
                    bits_seen  = bits_seen + 1'b1;
                    if (bits_seen == FRAME_BITS)
                    begin
                        r.frame_done = 1'b1;
                        sum8 = frame_bits[39:32] + frame_bits[31:24]
                             + frame_bits[23:16] + frame_bits[15:8];
                        if (sum8 == frame_bits[7:0])
                        begin
                            r.checksum_ok = 1'b1;
                            hum_held      = frame_bits[39:32];
                            temp_held     = frame_bits[23:16];
                        end
                    end
                end
            end
            KIND_READING:
            begin
                if (msb == lsb)
                begin
                    reading_held = msb;
                end
            end
            default:
            begin
            end
        endcase

        r.humidity    = hum_held;
        r.temperature = temp_held;
        r.alarm       = (temp_held > temp_limit) || (hum_held > hum_limit);
        if (moist_thr > 8'd100)
        begin
            r.pump_on = 1'b1;
        end
        else
        begin
            r.pump_on = (100 * int'(reading_held)) > (255 * (100 - int'(moist_thr)));
        end
        r.moisture_percent = PCT_W'((25500 - 100 * int'(reading_held)) / 255);
        return r;
    endfunction

    function automatic bit field_differs(input string name,
                                         input logic [BYTE_W-1:0] want,
                                         input logic [BYTE_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic compare_report();
        monitor_report_t want;
        bit bad;
        if (predicted_reports.size() == 0)
        begin
            $error("result transaction with no prediction waiting");
            mismatches++;
        end
        else
        begin
            want = predicted_reports.pop_front();
            bad  = 1'b0;
            bad |= field_differs("humidity", want.humidity, result.humidity);
            bad |= field_differs("temperature", want.temperature, result.temperature);
            bad |= field_differs("alarm", BYTE_W'(want.alarm), BYTE_W'(result.alarm));
            bad |= field_differs("pump_on", BYTE_W'(want.pump_on),
                                 BYTE_W'(result.pump_on));
            bad |= field_differs("moisture_percent", BYTE_W'(want.moisture_percent),
                                 BYTE_W'(result.moisture_percent));
            bad |= field_differs("frame_done", BYTE_W'(want.frame_done),
                                 BYTE_W'(result.frame_done));
            bad |= field_differs("checksum_ok", BYTE_W'(want.checksum_ok),
                                 BYTE_W'(result.checksum_ok));
            if (bad)
            begin
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_bits   = '0;
            bits_seen    = '0;
            hum_held     = '0;
            temp_held    = '0;
            reading_held = '0;
            temp_limit   = TLIM_RESET;
            hum_limit    = HLIM_RESET;
            moist_thr    = THR_RESET;
            mismatches   = 0;
            predicted_reports.delete();
            pending <= 0;
        end
        else
        begin
            // older results leave first, so compare before predicting
            if (result.valid && result.ready)
            begin
                compare_report();
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_TEMP_LIMIT: temp_limit = cfg.data[TLIM_W-1:0];
                    REG_HUM_LIMIT:  hum_limit  = cfg.data[HLIM_W-1:0];
                    REG_MOIST_THR:  moist_thr  = cfg.data;
                    default:
                    begin
                    end
                endcase
            end
            if (sample.valid && sample.ready)
            begin
                predicted_reports.push_back(advance_monitor(sample.kind, sample.bit_value,
                                                            sample.reading_msb_first,
                                                            sample.reading_lsb_first));
            end
            pending <= predicted_reports.size();
        end
    end

endmodule

// ===== sim/humidity_frame_watering_monitor_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_frame_watering_monitor_test : top of the monitor testbench
// drives sample and configuration transactions, paces the result side and
// gives the verdict; a side checker predicts and compares every result
// ----------------------------------------------------------------------------
module humidity_frame_watering_monitor_test;
    import hfwm_pkg::*;

    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 4;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 200;
    // the block has one result register, this extra wait covers any straggler
    localparam int DRAIN_CYCLES    = 4;
    // cycles without any transaction before the run is declared hung
    localparam int STALL_LIMIT     = 1000;

    // codes the package leaves unnamed
    localparam logic [1:0]           KIND_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;

    // pacing of the two sides
    typedef enum int {
        PACE_SLOW_SINK,
        PACE_SLOW_SOURCE,
        PACE_FULL
    } pace_t;

    logic clk = 1'b0;
    logic rst_n;

    int source_idle_pct;
    int sink_idle_pct;
    int items_sent;
    int fail_count;
    int pending;

    hfwm_sample_if sample_ch();
    hfwm_result_if result_ch();
    hfwm_cfg_if    cfg_ch();

    humidity_frame_watering_monitor DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    hfwm_monitor_checker monitor_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample_ch),
        .result     (result_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #HALF_PERIOD clk = ~clk;

    // result side: ready drops at random according to the current pace
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // watchdog: any transaction on any channel restarts the count
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) ||
                (result_ch.valid && result_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic set_pace(input pace_t pace);
        case (pace)
            PACE_SLOW_SINK:
            begin
                source_idle_pct = 21;
                sink_idle_pct   = 75;
            end
            PACE_SLOW_SOURCE:
            begin
                source_idle_pct = 75;
                sink_idle_pct   = 21;
            end
            default:
            begin
                source_idle_pct = 0;
                sink_idle_pct   = 0;
            end
        endcase
    endtask

    // one sample transaction; valid stays high afterwards so that items can go back
    // to back, the idle wait of the next call or a drain lowers it
    task automatic send_sample(input logic [1:0]        kind,
                               input logic              bitv,
                               input logic [BYTE_W-1:0] msb,
                               input logic [BYTE_W-1:0] lsb);
        while ($urandom_range(0, 99) < source_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid             <= 1'b1;
        sample_ch.kind              <= kind;
        sample_ch.bit_value         <= bitv;
        sample_ch.reading_msb_first <= msb;
        sample_ch.reading_lsb_first <= lsb;
        do
        begin
            @(posedge clk);
        end
        while (!sample_ch.ready);
        // the unused kind is ignored by the block and does not count
        if (kind != KIND_UNUSED)
        begin
            items_sent++;
        end
    endtask

    // payload fields that the item kind does not use still toggle
    task automatic send_bit(input logic bitv);
        send_sample(KIND_BIT, bitv, BYTE_W'($urandom), BYTE_W'($urandom));
    endtask

    task automatic send_start();
        send_sample(KIND_START, 1'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
    endtask

    // converter reading; disagreeing copies differ in at least one bit
    task automatic send_reading(input logic [BYTE_W-1:0] level, input bit agree);
        logic [BYTE_W-1:0] other;
        other = agree ? level : (level ^ BYTE_W'($urandom_range(1, 255)));
        send_sample(KIND_READING, 1'($urandom), level, other);
    endtask

    // full sensor frame, MSB first, optionally with a corrupted checksum and
    // trailing bits that must be ignored
    task automatic send_frame(input logic [BYTE_W-1:0] hum,
                              input logic [BYTE_W-1:0] hum_frac,
                              input logic [BYTE_W-1:0] temp,
                              input logic [BYTE_W-1:0] temp_frac,
                              input bit                good_sum,
                              input int                extra);
        logic [BYTE_W-1:0]     ck;
        logic [FRAME_BITS-1:0] frame;
        ck = hum + hum_frac + temp + temp_frac;
        if (!good_sum)
        begin
            ck = ck + BYTE_W'($urandom_range(1, 255));
        end
        frame = {hum, hum_frac, temp, temp_frac, ck};
        send_start();
        for (int i = FRAME_BITS - 1; i >= 0; i--)
        begin
            send_bit(frame[i]);
        end
        repeat (extra)
        begin
            send_bit(1'($urandom));
        end
    endtask

    // climate byte: mostly near the alarm limits, sometimes anything
    function automatic logic [BYTE_W-1:0] pick_climate_byte(input int span);
        if ($urandom_range(0, 99) < 60)
        begin
            return BYTE_W'($urandom_range(0, span));
        end
        return BYTE_W'($urandom);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_level();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
        begin
            return '0;
        end
        if (roll < 20)
        begin
            return '1;
        end
        return BYTE_W'($urandom);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // lower valid and wait until every predicted result has been taken
    task automatic drain();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register settings per phase, both ends of every range included
    task automatic load_setting(input int phase);
        case (phase)
            0:
            begin
                // the spare index must leave all registers alone
                write_reg(REG_UNUSED, BYTE_W'($urandom));
                write_reg(REG_TEMP_LIMIT, 8'd0);
                write_reg(REG_HUM_LIMIT, 8'd0);
                write_reg(REG_MOIST_THR, 8'd0);
            end
            1:
            begin
                write_reg(REG_TEMP_LIMIT, 8'd45);
                write_reg(REG_HUM_LIMIT, 8'd85);
                write_reg(REG_MOIST_THR, 8'd100);
            end
            2:
            begin
                // bits above the width of the temperature and humidity limits are dropped
                write_reg(REG_TEMP_LIMIT, 8'hFF);
                write_reg(REG_HUM_LIMIT, 8'hFF);
                write_reg(REG_MOIST_THR, 8'd101);
            end
            3:
            begin
                write_reg(REG_TEMP_LIMIT, 8'd20);
                write_reg(REG_HUM_LIMIT, 8'd40);
                write_reg(REG_MOIST_THR, 8'd254);
            end
            4:
            begin
                write_reg(REG_TEMP_LIMIT, 8'd35);
                write_reg(REG_HUM_LIMIT, 8'd50);
                write_reg(REG_MOIST_THR, 8'd255);
            end
            default:
            begin
                write_reg(REG_TEMP_LIMIT, BYTE_W'($urandom_range(0, 45)));
                write_reg(REG_HUM_LIMIT, BYTE_W'($urandom_range(0, 85)));
                write_reg(REG_MOIST_THR, BYTE_W'($urandom_range(0, 254)));
            end
        endcase
    endtask

    // short directed run at reset settings: reading extremes, the two
    // single-bit patterns as disagreeing copies, ignored kind, a frame
    // restarted part way
    task automatic run_directed();
        send_reading(8'h00, 1'b1);
        send_reading(8'hFF, 1'b1);
        send_sample(KIND_READING, 1'b0, 8'h01, 8'h80);
        send_sample(KIND_READING, 1'b1, 8'h80, 8'h01);
        send_reading(8'h80, 1'b1);
        send_reading(8'h01, 1'b1);
        send_sample(KIND_UNUSED, 1'b1, 8'hFF, 8'hFF);
        send_sample(KIND_UNUSED, 1'b0, 8'h00, 8'h00);
        send_start();
        send_bit(1'b1);
        send_bit(1'b0);
        send_bit(1'b1);
        send_bit(1'b1);
        send_bit(1'b0);
        send_bit(1'b1);
        // restart mid-frame, the partial bits must be thrown away
        send_start();
        send_bit(1'b0);
        send_bit(1'b1);
        send_reading(8'd204, 1'b1);
        send_reading(8'd203, 1'b0);
    endtask

    // one random sequence; mostly whole frames and readings so that checksum
    // matching and latching get exercised, the rest noise
    task automatic send_random_sequence();
        int roll;
        int count;
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            send_frame(pick_climate_byte(100), BYTE_W'($urandom),
                       pick_climate_byte(60), BYTE_W'($urandom),
                       $urandom_range(0, 99) < 80,
                       ($urandom_range(0, 99) < 70) ? 0 : $urandom_range(1, 3));
        end
        else if (roll < 65)
        begin
            // frame cut short, to be overtaken by the next start
            count = $urandom_range(0, FRAME_BITS - 1);
            send_start();
            repeat (count)
            begin
                send_bit(1'($urandom));
            end
        end
        else if (roll < 85)
        begin
            count = $urandom_range(1, 4);
            repeat (count)
            begin
                send_reading(pick_level(), $urandom_range(0, 99) < 80);
            end
        end
        else if (roll < 95)
        begin
            send_sample(2'($urandom_range(0, 2)), 1'($urandom),
                        BYTE_W'($urandom), BYTE_W'($urandom));
        end
        else
        begin
            send_sample(KIND_UNUSED, 1'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
        end
    endtask

    // stimulus and verdict
    initial
    begin
        int goal;
        rst_n                       <= 1'b0;
        sample_ch.valid             <= 1'b0;
        sample_ch.kind              <= KIND_START;
        sample_ch.bit_value         <= 1'b0;
        sample_ch.reading_msb_first <= '0;
        sample_ch.reading_lsb_first <= '0;
        cfg_ch.valid                <= 1'b0;
        cfg_ch.index                <= REG_TEMP_LIMIT;
        cfg_ch.data                 <= '0;
        items_sent = 0;
        set_pace(PACE_SLOW_SINK);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();

        // two phases per pacing: slow sink, slow source, then flat out
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            if (phase == 2)
            begin
                set_pace(PACE_SLOW_SOURCE);
            end
            else if (phase == 4)
            begin
                set_pace(PACE_FULL);
            end
            load_setting(phase);
            goal = items_sent + ITEMS_PER_PHASE;
            while (items_sent < goal)
            begin
                send_random_sequence();
            end
        end
        drain();

        if (fail_count == 0 && pending == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
